// File: rtl/core/lru_key_value_cache_macros.svh
// Assertion macros used by the cache RTL (included in lkvc_store).
// Needs nothing else; include it inside a module body.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// The condition must hold at every clock edge once reset is released.
`define LKVC_ASSERT_HOLD(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// When the trigger holds, the condition must hold in the next cycle.
`define LKVC_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

// File: rtl/core/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by every module of the cache.
package lkvc_pkg;

   // Field widths.
   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;

   // Default slot count for the top-level parameter.
   localparam int MAX_ENTRIES_DEF = 16;

   // Capacity register value after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Value returned on a get miss and on every put.
   localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

   // Request type codes.
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   // One result word.
   typedef struct packed {
      logic                     found;
      logic signed [DATA_W-1:0] read_value;
      logic                     evicted;
   } lkvc_result_type;

endpackage

// File: rtl/core/lkvc_store.sv
// Slot storage, parallel key lookup and LRU age-rank update of the cache.
// Depends on lkvc_pkg and lru_key_value_cache_macros.svh.
module lkvc_store
   import lkvc_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     op_en,
   input  logic                     op_type,
   input  logic signed [DATA_W-1:0] op_key,
   input  logic signed [DATA_W-1:0] op_value,
   input  logic                     cap_write,
   input  logic [CAP_W-1:0]         cap_data,
   output lkvc_result_type          result
);

   `include "lru_key_value_cache_macros.svh"

   localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [MAX_ENTRIES-1:0] ONE_VEC = MAX_ENTRIES'(1);

   // Slot state.
   logic [MAX_ENTRIES-1:0]   valid_ff, valid_in;
   logic [RANK_W-1:0]        rank_ff [MAX_ENTRIES];
   logic [RANK_W-1:0]        rank_in [MAX_ENTRIES];
   logic signed [DATA_W-1:0] key_ff  [MAX_ENTRIES];
   logic signed [DATA_W-1:0] value_ff[MAX_ENTRIES];
   logic [CNT_W-1:0]         live_ff, live_in;
   logic [CAP_W-1:0]         cap_ff;

   // Lookup signals.
   logic [MAX_ENTRIES-1:0]   match, hit_oh, free_vec, free_oh, lru_oh, tgt_oh;
   logic [MAX_ENTRIES-1:0]   key_wr, value_wr;
   logic                     hit_any, free_any, lru_any;
   logic                     is_put, at_cap, evict_en, insert_en;
   logic [RANK_W-1:0]        hit_rank, lru_rank;
   logic signed [DATA_W-1:0] hit_value;
   logic [CMP_W-1:0]         cap_ext, eff_cap, live_ext;

   // Effective capacity: zero acts as one, large values saturate.
   always_comb begin
      cap_ext  = CMP_W'(cap_ff);
      live_ext = CMP_W'(live_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
         eff_cap = CMP_W'(MAX_ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
      at_cap = (live_ext >= eff_cap);
   end

   // Parallel compare, lowest free slot and least recent slot.
   always_comb begin
      lru_rank = RANK_W'(live_ff - CNT_W'(1));
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match[i]  = valid_ff[i] && (key_ff[i] == op_key);
         lru_oh[i] = valid_ff[i] && (rank_ff[i] == lru_rank);
      end
      hit_oh   = match & (~match + ONE_VEC);
      free_vec = ~valid_ff;
      free_oh  = free_vec & (~free_vec + ONE_VEC);
      hit_any  = |match;
      free_any = |free_vec;
      lru_any  = |lru_oh;
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         hit_rank  = hit_rank | ({RANK_W{hit_oh[i]}} & rank_ff[i]);
         hit_value = hit_value | ({DATA_W{hit_oh[i]}} & value_ff[i]);
      end
   end

   // Replacement decision for a put of a new key.
   always_comb begin
      is_put    = (op_type == REQ_PUT);
      evict_en  = is_put && !hit_any && (at_cap || !free_any) && lru_any;
      tgt_oh    = evict_en ? lru_oh : free_oh;
      insert_en = is_put && !hit_any && (|tgt_oh);
   end

   // Next state of valid bits, ranks and live count; slot write enables.
   always_comb begin
      valid_in = valid_ff;
      live_in  = live_ff;
      key_wr   = '0;
      value_wr = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (cap_write) begin
         valid_in = '0;
         live_in  = '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_in[i] = '0;
         end
      end else if (op_en && hit_any) begin
         // Promote the hit slot; younger slots age by one.
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (hit_oh[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
               rank_in[i] = RANK_W'(rank_ff[i] + 1'b1);
            end
         end
         if (is_put) begin
            value_wr = hit_oh;
         end
      end else if (op_en && insert_en) begin
         // Every surviving slot ages; the new key enters as most recent.
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (tgt_oh[i]) begin
               rank_in[i]  = '0;
               valid_in[i] = 1'b1;
            end else if (valid_ff[i]) begin
               rank_in[i] = RANK_W'(rank_ff[i] + 1'b1);
            end
         end
         key_wr   = tgt_oh;
         value_wr = tgt_oh;
         if (!evict_en) begin
            live_in = CNT_W'(live_ff + 1'b1);
         end
      end
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         live_ff  <= '0;
         cap_ff   <= CAP_RESET;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         live_ff  <= live_in;
         if (cap_write) begin
            cap_ff <= cap_data;
         end
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // Key and value storage, written without reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (key_wr[i]) begin
            key_ff[i] <= op_key;
         end
         if (value_wr[i]) begin
            value_ff[i] <= op_value;
         end
      end
   end

   // Result word for the current request.
   always_comb begin
      result.found      = hit_any;
      result.read_value = (hit_any && !is_put) ? hit_value : MISS_VALUE;
      result.evicted    = evict_en;
   end

   `LKVC_ASSERT_HOLD(a_live_matches_valid, clock, reset, $countones(valid_ff) == int'(live_ff), "live count differs from valid slots")
   `LKVC_ASSERT_HOLD(a_key_unique, clock, reset, $onehot0(match), "key held in more than one slot")
   `LKVC_ASSERT_NEXT(a_evict_keeps_count, clock, reset, op_en && insert_en && evict_en, live_ff == $past(live_ff), "eviction changed the live count")
   `LKVC_ASSERT_NEXT(a_clear_empties, clock, reset, cap_write, (live_ff == '0) && (valid_ff == '0), "capacity write did not clear the store")

endmodule

// File: rtl/core/lru_key_value_cache.sv
// Timing: a request is accepted into the input register, and its result word is captured in
// the output register once that is free, from which it drives the response ports.
// Throughput: one request per cycle while the response side does not stall, set by the
// slot lookup and rank update in lkvc_store; a stalled result holds the input register.
// Reset (synchronous, active high) empties the store, sets capacity to 16.
// Depends on lkvc_pkg and lkvc_store.
module lru_key_value_cache
   import lkvc_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // Request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_type,
   input  logic signed [DATA_W-1:0] req_key,
   input  logic signed [DATA_W-1:0] req_value,
   // Response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_found,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic                     rsp_evicted,
   // Capacity register write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CAP_W-1:0]         csr_active_capacity
);

   logic                     in_valid_ff, in_valid_in;
   logic                     in_type_ff;
   logic signed [DATA_W-1:0] in_key_ff, in_value_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   lkvc_result_type          rsp_ff, op_result;
   logic                     out_free, process, req_take, cap_write;

   // Handshake: the held word is processed once the output register frees up.
   // Nothing is taken in while reset is asserted.
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      process   = in_valid_ff && out_free;
      req_stall = reset || (in_valid_ff && !out_free);
      req_take  = req_valid && !req_stall;
      csr_ready = !reset && !in_valid_ff;
      cap_write = csr_valid && csr_ready;
   end

   // Valid flags of the input and output registers.
   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (process ? 1'b0 : in_valid_ff);
      rsp_valid_in = process ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers of both sides.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff  <= req_type;
         in_key_ff   <= req_key;
         in_value_ff <= req_value;
      end
      if (process) begin
         rsp_ff <= op_result;
      end
   end

   // Slot storage and lookup.
   lkvc_store #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .op_en     (process),
      .op_type   (in_type_ff),
      .op_key    (in_key_ff),
      .op_value  (in_value_ff),
      .cap_write (cap_write),
      .cap_data  (csr_active_capacity),
      .result    (op_result)
   );

   // Response word.
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_ff.found;
   assign rsp_read_value = rsp_ff.read_value;
   assign rsp_evicted    = rsp_ff.evicted;

endmodule
